// ----- sv/two_reader_shared_buffer_top_assert.svh -----
// Assertion macros for the buffer sequencer module.
// Each expects clk and rst_n in the scope where it is used.
`ifndef TWO_READER_SHARED_BUFFER_TOP_ASSERT_SVH
`define TWO_READER_SHARED_BUFFER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/trsb_pkg.sv -----
`default_nettype none

package trsb_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF     = 64;
  localparam int RECORD_WIDTH_DEF = 64;

  // Fixed port widths
  localparam int OP_W       = 2;
  localparam int REC_PORT_W = 64;
  localparam int POS_W      = 8;
  localparam int CNT_PORT_W = 7;
  localparam int MARK_W     = 2;

  localparam logic [MARK_W-1:0] BOTH_MARKS = 2'b11;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_PURGE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SEEN  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_PURGE = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  // Result beat handed from the controller to the output stage
  typedef struct packed {
    status_t                 status;
    logic [REC_PORT_W-1:0]   record;
    logic [CNT_PORT_W-1:0]   entry_count;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/two_reader_shared_buffer_top.sv -----
// Ordered buffer of up to CAPACITY records shared by two readers, each entry
// carrying one read mark per reader. One beat in gives one beat out. Insert
// and any operation that finds the buffer full or empty go from idle straight
// to the result state. Remove-head and read first pass a fetch state that
// waits for the registered entry memory read data; read then does its
// read-modify-write of the marks. Purge walks the held entries in order: the
// compaction walk reads one entry per cycle and writes each survivor through
// the read port and the write port of the entry memory. A new beat is
// accepted once the previous result has left the sequencer, while that
// result may still wait in the output register. No clearing pass is needed
// after reset.
`default_nettype none

module two_reader_shared_buffer_top #(
  parameter int CAPACITY     = trsb_pkg::CAPACITY_DEF,
  parameter int RECORD_WIDTH = trsb_pkg::RECORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [trsb_pkg::OP_W-1:0]          in_operation,
  input  wire logic [trsb_pkg::REC_PORT_W-1:0]    in_payload,
  input  wire logic                               in_reader_select,
  input  wire logic [trsb_pkg::POS_W-1:0]         in_position,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_status,
  output logic [trsb_pkg::REC_PORT_W-1:0]         out_record,
  output logic [trsb_pkg::CNT_PORT_W-1:0]         out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = RECORD_WIDTH + trsb_pkg::MARK_W;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [EW-1:0]  mem_wdata, mem_rdata;
  logic           res_valid, res_ready;
  trsb_pkg::res_t res;

  logic           out_valid_r, out_valid_nxt;
  trsb_pkg::res_t out_res_r;
  logic           load;

  trsb_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  trsb_ctrl #(
    .CAPACITY     (CAPACITY),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_payload       (in_payload),
    .in_reader_select (in_reader_select),
    .in_position      (in_position),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_record      = out_res_r.record;
  assign out_entry_count = out_res_r.entry_count;

endmodule

`default_nettype wire

// ----- sv/trsb_mem.sv -----
`default_nettype none

// Simple dual-port entry store, registered read data
module trsb_mem #(
  parameter int DEPTH = trsb_pkg::CAPACITY_DEF,
  parameter int WIDTH = trsb_pkg::RECORD_WIDTH_DEF + trsb_pkg::MARK_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/trsb_ctrl.sv -----
`default_nettype none

`include "two_reader_shared_buffer_top_assert.svh"

// Operation sequencer: ring pointers, read-modify-write, purge compaction
module trsb_ctrl #(
  parameter int CAPACITY     = trsb_pkg::CAPACITY_DEF,
  parameter int RECORD_WIDTH = trsb_pkg::RECORD_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [trsb_pkg::OP_W-1:0]             in_operation,
  input  wire logic [trsb_pkg::REC_PORT_W-1:0]       in_payload,
  input  wire logic                                  in_reader_select,
  input  wire logic [trsb_pkg::POS_W-1:0]            in_position,
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output trsb_pkg::res_t                             res,
  output logic                                       mem_we,
  output logic [$clog2(CAPACITY)-1:0]                mem_waddr,
  output logic [RECORD_WIDTH+trsb_pkg::MARK_W-1:0]   mem_wdata,
  output logic                                       mem_re,
  output logic [$clog2(CAPACITY)-1:0]                mem_raddr,
  input  wire logic [RECORD_WIDTH+trsb_pkg::MARK_W-1:0] mem_rdata
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int XW   = (CW > trsb_pkg::POS_W) ? CW : trsb_pkg::POS_W;
  localparam int RW   = RECORD_WIDTH;
  localparam int MW   = trsb_pkg::MARK_W;
  localparam int OUTW = trsb_pkg::REC_PORT_W;
  localparam int CNTW = trsb_pkg::CNT_PORT_W;

  localparam logic [AW:0]   CAP_A     = (AW+1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  // ring slot of base + offset, both below capacity
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_A) begin
      sum = sum - CAP_A;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  trsb_pkg::state_t  state_r, state_nxt;
  trsb_pkg::op_t     op_r, op_nxt;
  trsb_pkg::status_t status_r, status_nxt;
  logic [RW-1:0]     record_r, record_nxt;
  logic              reader_r, reader_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [AW-1:0]     rd_slot_r, rd_slot_nxt;
  logic [AW-1:0]     wr_slot_r, wr_slot_nxt;
  logic [CW-1:0]     walk_r, walk_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;

  logic [XW-1:0]     pos_x, cnt_x, idx_x;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     rd_next;
  logic [RW-1:0]     rd_rec;
  logic [MW-1:0]     rd_marks;
  logic [MW-1:0]     reader_bit;
  logic [CW-1:0]     kept_cur;
  logic              is_empty;

  // clamp read position to the tail
  always_comb begin
    pos_x = XW'(in_position);
    cnt_x = XW'(count_r);
    idx_x = (pos_x >= cnt_x) ? cnt_x - XW'(1) : pos_x;
    idx   = idx_x[AW-1:0];
  end

  assign rd_rec     = mem_rdata[RW-1:0];
  assign rd_marks   = mem_rdata[RW+MW-1:RW];
  assign reader_bit = reader_r ? 2'b10 : 2'b01;
  assign is_empty   = (count_r == '0);
  assign rd_next    = slot_inc(rd_slot_r);
  assign kept_cur   = (rd_marks != trsb_pkg::BOTH_MARKS) ? kept_r + ONE_C : kept_r;

  // next-state and memory control
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    record_nxt  = record_r;
    reader_nxt  = reader_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    slot_nxt    = slot_r;
    rd_slot_nxt = rd_slot_r;
    wr_slot_nxt = wr_slot_r;
    walk_nxt    = walk_r;
    kept_nxt    = kept_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    in_stall    = (state_r != trsb_pkg::S_IDLE);
    res_valid   = 1'b0;

    case (state_r)
      trsb_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt     = trsb_pkg::op_t'(in_operation);
          reader_nxt = in_reader_select;
          status_nxt = trsb_pkg::ST_OK;
          record_nxt = '0;
          state_nxt  = trsb_pkg::S_FIN;
          case (trsb_pkg::op_t'(in_operation))
            trsb_pkg::OP_INSERT: begin
              if (count_r == CAP_C) begin
                status_nxt = trsb_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_add(head_r, count_r[AW-1:0]);
                mem_wdata = {{MW{1'b0}}, in_payload[RW-1:0]};
                count_nxt = count_r + ONE_C;
              end
            end
            trsb_pkg::OP_REMOVE: begin
              if (is_empty) begin
                status_nxt = trsb_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = trsb_pkg::S_FETCH;
              end
            end
            trsb_pkg::OP_READ: begin
              if (is_empty) begin
                status_nxt = trsb_pkg::ST_EMPTY;
              end else begin
                slot_nxt  = slot_add(head_r, idx);
                mem_re    = 1'b1;
                mem_raddr = slot_nxt;
                state_nxt = trsb_pkg::S_FETCH;
              end
            end
            trsb_pkg::OP_PURGE: begin
              if (is_empty) begin
                status_nxt = trsb_pkg::ST_EMPTY;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = head_r;
                rd_slot_nxt = head_r;
                wr_slot_nxt = head_r;
                walk_nxt    = '0;
                kept_nxt    = '0;
                state_nxt   = trsb_pkg::S_PURGE;
              end
            end
            default: begin
              state_nxt = trsb_pkg::S_IDLE;
            end
          endcase
        end
      end

      // entry data is back: pop the head or mark and return
      trsb_pkg::S_FETCH: begin
        state_nxt = trsb_pkg::S_FIN;
        if (op_r == trsb_pkg::OP_REMOVE) begin
          record_nxt = rd_rec;
          head_nxt   = slot_inc(head_r);
          count_nxt  = count_r - ONE_C;
        end else if ((rd_marks & reader_bit) != '0) begin
          status_nxt = trsb_pkg::ST_SEEN;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = slot_r;
          mem_wdata  = {rd_marks | reader_bit, rd_rec};
          record_nxt = rd_rec;
        end
      end

      // compaction walk: one entry per cycle, survivors move toward the head
      trsb_pkg::S_PURGE: begin
        if (rd_marks != trsb_pkg::BOTH_MARKS) begin
          mem_we      = 1'b1;
          mem_waddr   = wr_slot_r;
          mem_wdata   = mem_rdata;
          wr_slot_nxt = slot_inc(wr_slot_r);
        end
        kept_nxt = kept_cur;
        if (walk_r + ONE_C == count_r) begin
          count_nxt = kept_cur;
          state_nxt = trsb_pkg::S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_next;
          rd_slot_nxt = rd_next;
          walk_nxt    = walk_r + ONE_C;
        end
      end

      trsb_pkg::S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = trsb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = trsb_pkg::S_IDLE;
      end
    endcase
  end

  // result beat
  always_comb begin
    res.status      = status_r;
    res.record      = OUTW'(record_r);
    res.entry_count = CNTW'(count_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trsb_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // per-operation working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    record_r  <= record_nxt;
    reader_r  <= reader_nxt;
    slot_r    <= slot_nxt;
    rd_slot_r <= rd_slot_nxt;
    wr_slot_r <= wr_slot_nxt;
    walk_r    <= walk_nxt;
    kept_r    <= kept_nxt;
  end

  `TRSB_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CAP_C, "entry count above capacity")
  `TRSB_ASSERT_NOW(a_purge_order, state_r == trsb_pkg::S_PURGE,
    (kept_r <= walk_r) && (walk_r < count_r), "purge write pointer ahead of scan")
  `TRSB_ASSERT_NOW(a_fetch_write, (state_r == trsb_pkg::S_FETCH) && mem_we,
    op_r == trsb_pkg::OP_READ, "write-back outside a read")
  `TRSB_ASSERT_NEXT(a_fin_done, (state_r == trsb_pkg::S_FIN) && res_ready,
    state_r == trsb_pkg::S_IDLE, "result taken but sequencer not idle")

endmodule

`default_nettype wire

// ----- bench/tb_two_reader_shared_buffer_top.sv -----
`default_nettype none

module tb_two_reader_shared_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trsb_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = CAP + 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_OPS     = 800;
  localparam logic [REC_PORT_W-1:0] REC_MASK = {REC_PORT_W{1'b1}} >> (64 - RECORD_WIDTH_DEF);

  // One command beat as the driver presents it
  typedef struct {
    op_t                 op;
    logic [REC_PORT_W-1:0] payload;
    logic                reader;
    logic [POS_W-1:0]    position;
  } op_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = OP_INSERT;
  logic [REC_PORT_W-1:0] in_payload = '0;
  logic                  in_reader_select = 1'b0;
  logic [POS_W-1:0]      in_position = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [REC_PORT_W-1:0] out_record;
  logic [CNT_PORT_W-1:0] out_entry_count;

  op_beat_t    op_queue[$];
  res_t        reply_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_done = 0;
  int unsigned recv_beats = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the buffer contents
  logic [REC_PORT_W-1:0] shadow_rec [CAP];
  logic [MARK_W-1:0]     shadow_marks [CAP];
  int unsigned           shadow_head = 0;
  int unsigned           shadow_count = 0;

  two_reader_shared_buffer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_payload      (in_payload),
    .in_reader_select(in_reader_select),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_record      (out_record),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot_at(int unsigned offset);
    return (shadow_head + offset) % CAP;
  endfunction

  // Apply one command to the shadow buffer, return the reply it must produce
  function automatic res_t shadow_apply(op_beat_t b);
    res_t              r;
    int unsigned       idx;
    int unsigned       s;
    int unsigned       kept;
    int unsigned       i;
    logic [MARK_W-1:0] mark;
    r.status = ST_OK;
    r.record = '0;
    mark = b.reader ? 2'b10 : 2'b01;
    case (b.op)
      OP_INSERT: begin
        if (shadow_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          s = slot_at(shadow_count);
          shadow_rec[s]   = b.payload & REC_MASK;
          shadow_marks[s] = '0;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.record = shadow_rec[shadow_head];
          shadow_marks[shadow_head] = '0;
          shadow_head = slot_at(1);
          shadow_count--;
        end
      end
      OP_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // positions past the tail land on the tail
          idx = (b.position >= shadow_count) ? shadow_count - 1 : b.position;
          s = slot_at(idx);
          if ((shadow_marks[s] & mark) != '0) begin
            r.status = ST_SEEN;
          end else begin
            shadow_marks[s] = shadow_marks[s] | mark;
            r.record = shadow_rec[s];
          end
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // compact survivors toward the head, order kept
          kept = 0;
          for (i = 0; i < shadow_count; i++) begin
            s = slot_at(i);
            if ((shadow_marks[s] & BOTH_MARKS) != BOTH_MARKS) begin
              shadow_rec[slot_at(kept)]   = shadow_rec[s];
              shadow_marks[slot_at(kept)] = shadow_marks[s];
              kept++;
            end
          end
          for (i = kept; i < shadow_count; i++) begin
            shadow_marks[slot_at(i)] = '0;
          end
          shadow_count = kept;
        end
      end
    endcase
    r.entry_count = shadow_count[CNT_PORT_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [REC_PORT_W-1:0] rand_record();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_reader();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Mostly a held index, sometimes past the tail
  function automatic logic [POS_W-1:0] pick_position(int unsigned est);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return POS_W'($urandom_range(0, (est > 0) ? est - 1 : 0));
    if (roll < 90) return '1;
    return rand_pos();
  endfunction

  task automatic add_op(op_t op, logic [REC_PORT_W-1:0] payload, logic reader,
                        logic [POS_W-1:0] position);
    op_beat_t b;
    b.op       = op;
    b.payload  = payload;
    b.reader   = reader;
    b.position = position;
    op_queue.push_back(b);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int unsigned      est;
    int unsigned      n;
    int unsigned      k;
    logic [POS_W-1:0] p;
    for (int i = 0; i < CAP; i++) begin
      shadow_rec[i]   = '0;
      shadow_marks[i] = '0;
    end

    // empty buffer corners
    add_op(OP_REMOVE, '0, 1'b0, '0);
    add_op(OP_READ, '1, 1'b1, '1);
    add_op(OP_PURGE, '0, 1'b0, '0);
    // four entries, payload extremes
    add_op(OP_INSERT, '1, 1'b0, '0);
    add_op(OP_INSERT, '0, 1'b1, '1);
    add_op(OP_INSERT, 64'hA5A5_5A5A_F00F_0FF0, 1'b0, '0);
    add_op(OP_INSERT, rand_record(), 1'b1, 8'h55);
    // reads: head, repeat by same reader, tail clamp, index equal to count
    add_op(OP_READ, '0, 1'b0, 8'd0);
    add_op(OP_READ, '0, 1'b0, 8'd0);
    add_op(OP_READ, '0, 1'b1, '1);
    add_op(OP_READ, '0, 1'b1, 8'd4);
    add_op(OP_READ, '0, 1'b1, 8'd0);
    add_op(OP_READ, '0, 1'b0, 8'd2);
    add_op(OP_READ, '0, 1'b1, 8'd2);
    // purge drops entries 0 and 2, then a purge that deletes nothing
    add_op(OP_PURGE, '0, 1'b0, '0);
    add_op(OP_PURGE, '0, 1'b1, '1);
    add_op(OP_READ, '0, 1'b0, 8'd1);
    add_op(OP_REMOVE, '0, 1'b0, '0);
    add_op(OP_REMOVE, '0, 1'b1, '1);
    add_op(OP_REMOVE, '0, 1'b0, '0);

    // random phases; first one fills past full
    est = 0;
    for (k = 0; k < 66; k++) begin
      add_op(OP_INSERT, rand_record(), rand_reader(), rand_pos());
    end
    est = CAP;
    while (op_queue.size() < RANDOM_OPS + 86) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 20);
          for (k = 0; k < n; k++) begin
            add_op(OP_INSERT, rand_record(), rand_reader(), rand_pos());
          end
          est = (est + n > CAP) ? CAP : est + n;
        end
        3, 4, 5: begin
          n = $urandom_range(1, 30);
          for (k = 0; k < n; k++) begin
            add_op(OP_READ, rand_record(), rand_reader(), pick_position(est));
          end
        end
        6: begin
          add_op(OP_PURGE, rand_record(), rand_reader(), rand_pos());
        end
        7: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
          for (k = 0; k < n; k++) begin
            add_op(OP_REMOVE, rand_record(), rand_reader(), rand_pos());
          end
          est = (n > est) ? 0 : est - n;
        end
        8: begin
          // both readers read some entries, then purge them
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) begin
            p = pick_position(est);
            add_op(OP_READ, rand_record(), 1'b0, p);
            add_op(OP_READ, rand_record(), 1'b1, p);
          end
          add_op(OP_PURGE, rand_record(), rand_reader(), rand_pos());
          est = (n > est) ? 0 : est - n;
        end
        default: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            add_op(op_t'($urandom_range(0, 3)), rand_record(), rand_reader(), rand_pos());
          end
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (op_queue.size() != 0 || in_valid || reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Command driver
  always @(posedge clk) begin
    logic     fire;
    op_beat_t b;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || fire) begin
      if (fire) send_idle = pick_gap();
      if (send_idle > 0) begin
        send_idle--;
        in_valid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        b = op_queue.pop_front();
        in_valid         <= 1'b1;
        in_operation     <= b.op;
        in_payload       <= b.payload;
        in_reader_select <= b.reader;
        in_position      <= b.position;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reply receiver: random stalls plus two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) recv_beats++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_done < 2 && recv_beats >= ((hold_done == 0) ? 150 : 450)) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Predict on every accepted command, check every accepted reply
  always @(posedge clk) begin
    op_beat_t b;
    res_t     got;
    res_t     want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        b.op       = op_t'(in_operation);
        b.payload  = in_payload;
        b.reader   = in_reader_select;
        b.position = in_position;
        reply_queue.push_back(shadow_apply(b));
      end
      if (out_valid && !out_stall) begin
        got.status      = status_t'(out_status);
        got.record      = out_record;
        got.entry_count = out_entry_count;
        if (reply_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reply beat: status %0d record %h count %0d",
                     got.status, got.record, got.entry_count);
        end else begin
          want = reply_queue.pop_front();
          if (got.status !== want.status || got.record !== want.record ||
              got.entry_count !== want.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at %0t: exp st %0d rec %h cnt %0d, got st %0d rec %h cnt %0d",
                       $realtime, want.status, want.record, want.entry_count,
                       got.status, got.record, got.entry_count);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire
